// ===== src/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_RST(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(name, clk, rstn, prop, msg)

`define ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== src/qvr_pkg.sv =====
// types, widths and helpers for the quaternion vector rotation
package qvr_pkg;

  localparam int VEC_WIDTH  = 16;
  localparam int QUAT_WIDTH = 16;
  localparam int FRAC_BITS  = QUAT_WIDTH - 2;

  localparam int PROD1_W = VEC_WIDTH + QUAT_WIDTH;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int P_W     = VEC_WIDTH + 3;
  localparam int PROD2_W = P_W + QUAT_WIDTH;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int R_W     = SUM2_W - FRAC_BITS;

  localparam int NPROD = 12;

  localparam logic signed [SUM1_W-1:0] ROUND1 =
    {{(SUM1_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [SUM2_W-1:0] ROUND2 =
    {{(SUM2_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic signed [R_W-1:0] SAT_MAX =
    {{(R_W-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [R_W-1:0] SAT_MIN =
    {{(R_W-VEC_WIDTH+1){1'b1}}, {(VEC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
  } in_word_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
  } out_word_t;

  // intermediate quaternion p = conj(q) * v, with q carried alongside
  typedef struct packed {
    logic signed [P_W-1:0] pw;
    logic signed [P_W-1:0] px;
    logic signed [P_W-1:0] py;
    logic signed [P_W-1:0] pz;
    quat_t                 q;
  } mid_word_t;

  function automatic logic signed [VEC_WIDTH-1:0] sat_vec(input logic signed [R_W-1:0] a);
    logic signed [VEC_WIDTH-1:0] r;
    if (a > SAT_MAX) begin
      r = SAT_MAX[VEC_WIDTH-1:0];
    end else if (a < SAT_MIN) begin
      r = SAT_MIN[VEC_WIDTH-1:0];
    end else begin
      r = a[VEC_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/qvr_conj_mul.sv =====
// first hamilton product conj(q) * v, multiply stage then round stage
module qvr_conj_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qvr_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qvr_pkg::mid_word_t out_word_o
);
  import qvr_pkg::*;

  logic                       mul_valid_q;
  logic                       mul_ready;
  logic signed [PROD1_W-1:0]  prod_d [NPROD];
  logic signed [PROD1_W-1:0]  prod_q [NPROD];
  quat_t                      quat_q;

  logic                       sum_valid_q;
  logic                       sum_ready;
  logic signed [SUM1_W-1:0]   sum_w, sum_x, sum_y, sum_z;
  mid_word_t                  mid_d, mid_q;

  assign sum_ready  = !sum_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || sum_ready;
  assign in_ready_o = mul_ready;

  // scalar, i, j and k terms in groups of three
  assign prod_d[0]  = PROD1_W'(in_word_i.vec_x) * PROD1_W'(in_word_i.quat_x);
  assign prod_d[1]  = PROD1_W'(in_word_i.vec_y) * PROD1_W'(in_word_i.quat_y);
  assign prod_d[2]  = PROD1_W'(in_word_i.vec_z) * PROD1_W'(in_word_i.quat_z);
  assign prod_d[3]  = PROD1_W'(in_word_i.vec_x) * PROD1_W'(in_word_i.quat_w);
  assign prod_d[4]  = PROD1_W'(in_word_i.vec_z) * PROD1_W'(in_word_i.quat_y);
  assign prod_d[5]  = PROD1_W'(in_word_i.vec_y) * PROD1_W'(in_word_i.quat_z);
  assign prod_d[6]  = PROD1_W'(in_word_i.vec_y) * PROD1_W'(in_word_i.quat_w);
  assign prod_d[7]  = PROD1_W'(in_word_i.vec_z) * PROD1_W'(in_word_i.quat_x);
  assign prod_d[8]  = PROD1_W'(in_word_i.vec_x) * PROD1_W'(in_word_i.quat_z);
  assign prod_d[9]  = PROD1_W'(in_word_i.vec_z) * PROD1_W'(in_word_i.quat_w);
  assign prod_d[10] = PROD1_W'(in_word_i.vec_y) * PROD1_W'(in_word_i.quat_x);
  assign prod_d[11] = PROD1_W'(in_word_i.vec_x) * PROD1_W'(in_word_i.quat_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      prod_q   <= prod_d;
      quat_q.w <= in_word_i.quat_w;
      quat_q.x <= in_word_i.quat_x;
      quat_q.y <= in_word_i.quat_y;
      quat_q.z <= in_word_i.quat_z;
    end
  end

  always_comb begin
    sum_w = SUM1_W'(prod_q[0]) + SUM1_W'(prod_q[1]) + SUM1_W'(prod_q[2]) + ROUND1;
    sum_x = SUM1_W'(prod_q[3]) - SUM1_W'(prod_q[4]) + SUM1_W'(prod_q[5]) + ROUND1;
    sum_y = SUM1_W'(prod_q[6]) + SUM1_W'(prod_q[7]) - SUM1_W'(prod_q[8]) + ROUND1;
    sum_z = SUM1_W'(prod_q[9]) - SUM1_W'(prod_q[10]) + SUM1_W'(prod_q[11]) + ROUND1;
    mid_d.pw = sum_w[FRAC_BITS+P_W-1:FRAC_BITS];
    mid_d.px = sum_x[FRAC_BITS+P_W-1:FRAC_BITS];
    mid_d.py = sum_y[FRAC_BITS+P_W-1:FRAC_BITS];
    mid_d.pz = sum_z[FRAC_BITS+P_W-1:FRAC_BITS];
    mid_d.q  = quat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (sum_ready) begin
      sum_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && mul_valid_q) begin
      mid_q <= mid_d;
    end
  end

  assign out_valid_o = sum_valid_q;
  assign out_word_o  = mid_q;

endmodule

// ===== src/qvr_vec_mul.sv =====
// second hamilton product p * q, multiply stage then round and saturate stage
module qvr_vec_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qvr_pkg::mid_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qvr_pkg::out_word_t out_word_o
);
  import qvr_pkg::*;

  logic                       mul_valid_q;
  logic                       mul_ready;
  logic signed [PROD2_W-1:0]  prod_d [NPROD];
  logic signed [PROD2_W-1:0]  prod_q [NPROD];

  logic                       out_valid_q;
  logic                       out_ready;
  logic signed [SUM2_W-1:0]   sum_x, sum_y, sum_z;
  logic signed [R_W-1:0]      rnd_x, rnd_y, rnd_z;
  out_word_t                  res_d, res_q;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || out_ready;
  assign in_ready_o = mul_ready;

  // i, j and k terms in groups of four
  assign prod_d[0]  = PROD2_W'(in_word_i.pw) * PROD2_W'(in_word_i.q.x);
  assign prod_d[1]  = PROD2_W'(in_word_i.px) * PROD2_W'(in_word_i.q.w);
  assign prod_d[2]  = PROD2_W'(in_word_i.py) * PROD2_W'(in_word_i.q.z);
  assign prod_d[3]  = PROD2_W'(in_word_i.pz) * PROD2_W'(in_word_i.q.y);
  assign prod_d[4]  = PROD2_W'(in_word_i.pw) * PROD2_W'(in_word_i.q.y);
  assign prod_d[5]  = PROD2_W'(in_word_i.px) * PROD2_W'(in_word_i.q.z);
  assign prod_d[6]  = PROD2_W'(in_word_i.py) * PROD2_W'(in_word_i.q.w);
  assign prod_d[7]  = PROD2_W'(in_word_i.pz) * PROD2_W'(in_word_i.q.x);
  assign prod_d[8]  = PROD2_W'(in_word_i.pw) * PROD2_W'(in_word_i.q.z);
  assign prod_d[9]  = PROD2_W'(in_word_i.px) * PROD2_W'(in_word_i.q.y);
  assign prod_d[10] = PROD2_W'(in_word_i.py) * PROD2_W'(in_word_i.q.x);
  assign prod_d[11] = PROD2_W'(in_word_i.pz) * PROD2_W'(in_word_i.q.w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum_x = SUM2_W'(prod_q[0]) + SUM2_W'(prod_q[1]) + SUM2_W'(prod_q[2])
          - SUM2_W'(prod_q[3]) + ROUND2;
    sum_y = SUM2_W'(prod_q[4]) - SUM2_W'(prod_q[5]) + SUM2_W'(prod_q[6])
          + SUM2_W'(prod_q[7]) + ROUND2;
    sum_z = SUM2_W'(prod_q[8]) + SUM2_W'(prod_q[9]) - SUM2_W'(prod_q[10])
          + SUM2_W'(prod_q[11]) + ROUND2;
    rnd_x = sum_x[SUM2_W-1:FRAC_BITS];
    rnd_y = sum_y[SUM2_W-1:FRAC_BITS];
    rnd_z = sum_z[SUM2_W-1:FRAC_BITS];
    res_d.rot_x = sat_vec(rnd_x);
    res_d.rot_y = sat_vec(rnd_y);
    res_d.rot_z = sat_vec(rnd_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mul_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;

endmodule

// ===== src/quaternion_vector_rotation.sv =====
// top level of the quaternion vector rotation pipeline
// Rotates a signed vector by a Q2.14 quaternion as conj(q)*v*q (world to body
// sense) and returns the saturated vector part. One word is taken every clock
// cycle while the output does not stall, and passes through a multiply and a
// round stage for conj(q)*v (twelve 16x16 multipliers), then a multiply and a
// round-and-saturate stage for p*q (twelve 19x16 multipliers). The last stage
// is the output register, so a new word is taken while a result waits; when
// the output stalls, bubbles in the four stages are still filled before the
// input is held off. The quaternion is used as given and not normalised.
`include "assert_macros.svh"

module quaternion_vector_rotation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qvr_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qvr_pkg::out_word_t out_word_o
);
  import qvr_pkg::*;

  logic      mid_valid;
  logic      mid_ready;
  mid_word_t mid_word;

  qvr_conj_mul u_conj_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_word_o  (mid_word)
  );

  qvr_vec_mul u_vec_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_word_i   (mid_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `ASSERT_RST(a_ready_chain, clk_i, rst_ni, out_ready_i |-> in_ready_o, "input stalled while output ready")
  `ASSERT_RST(a_stall_full, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i && mid_valid && !mid_ready), "input stalled with a bubble in the pipe")
  `ASSERT_RST(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i) |=> out_valid_o, "word lost in the pipe")

endmodule

// ===== test/tb_quaternion_vector_rotation.sv =====
// testbench for the quaternion vector rotation: directed and random words against a predictor
module tb_quaternion_vector_rotation;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;

  localparam int STALL_PCT   = 35;
  localparam int WATCH_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;

  logic      clk_i;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_word_t  in_word     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_word_t out_word;

  bit        throttle_en = 1'b1;
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  out_word_t rot_expected_q[$];

  quaternion_vector_rotation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // round to nearest, ties upwards, dropping the quaternion fraction bits
  function automatic longint round_frac(input longint s);
    return (s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] clamp_vec(input longint s);
    longint hi;
    longint lo;
    hi = (longint'(1) << (VEC_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[VEC_WIDTH-1:0];
  endfunction

  // vector part of conj(q) * v * q
  function automatic out_word_t rotate_vector(input in_word_t iw);
    longint vx, vy, vz, qw, qx, qy, qz, pw, px, py, pz;
    out_word_t r;
    vx = $signed(iw.vec_x);
    vy = $signed(iw.vec_y);
    vz = $signed(iw.vec_z);
    qw = $signed(iw.quat_w);
    qx = $signed(iw.quat_x);
    qy = $signed(iw.quat_y);
    qz = $signed(iw.quat_z);
    pw = round_frac(vx * qx + vy * qy + vz * qz);
    px = round_frac(vx * qw - vz * qy + vy * qz);
    py = round_frac(vy * qw + vz * qx - vx * qz);
    pz = round_frac(vz * qw - vy * qx + vx * qy);
    r.rot_x = clamp_vec(round_frac(pw * qx + px * qw + py * qz - pz * qy));
    r.rot_y = clamp_vec(round_frac(pw * qy - px * qz + py * qw + pz * qx));
    r.rot_z = clamp_vec(round_frac(pw * qz + px * qy - py * qx + pz * qw));
    return r;
  endfunction

  function automatic in_word_t make_word(input int vx, input int vy, input int vz,
                                         input int qw, input int qx, input int qy,
                                         input int qz);
    in_word_t w;
    w.vec_x  = vx[VEC_WIDTH-1:0];
    w.vec_y  = vy[VEC_WIDTH-1:0];
    w.vec_z  = vz[VEC_WIDTH-1:0];
    w.quat_w = qw[QUAT_WIDTH-1:0];
    w.quat_x = qx[QUAT_WIDTH-1:0];
    w.quat_y = qy[QUAT_WIDTH-1:0];
    w.quat_z = qz[QUAT_WIDTH-1:0];
    return w;
  endfunction

  // random rotation, optionally scaled off the unit sphere
  function automatic in_word_t random_rotation(input bit off_unit);
    real a[4];
    real n;
    real g;
    in_word_t w;
    do begin
      n = 0.0;
      foreach (a[i]) begin
        a[i] = $itor($urandom_range(65535)) - 32768.0;
        n += a[i] * a[i];
      end
      n = $sqrt(n);
    end while (n < 1.0);
    g = off_unit ? $itor($urandom_range(199, 10)) / 100.0 : 1.0;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.quat_w = QUAT_WIDTH'($rtoi(a[0] / n * 16384.0 * g));
    w.quat_x = QUAT_WIDTH'($rtoi(a[1] / n * 16384.0 * g));
    w.quat_y = QUAT_WIDTH'($rtoi(a[2] / n * 16384.0 * g));
    w.quat_z = QUAT_WIDTH'($rtoi(a[3] / n * 16384.0 * g));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while (throttle_en && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (rot_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // result check first, then the new expectation, both on pre-edge values
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rot_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with nothing expected: %0d %0d %0d", $realtime,
                     out_word.rot_x, out_word.rot_y, out_word.rot_z);
        end else begin
          exp_w = rot_expected_q.pop_front();
          if (out_word.rot_x !== exp_w.rot_x || out_word.rot_y !== exp_w.rot_y ||
              out_word.rot_z !== exp_w.rot_z) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: rot mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       $realtime, exp_w.rot_x, exp_w.rot_y, exp_w.rot_z,
                       out_word.rot_x, out_word.rot_y, out_word.rot_z);
          end
        end
      end
      if (in_valid && in_ready)
        rot_expected_q.push_back(rotate_vector(in_word));
    end
  end

  always @(posedge clk_i) begin
    out_ready <= throttle_en ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    throttle_en = 1'b1;
    // identity, with vector extremes
    send_word(make_word(1000, -2000, 3000, 16384, 0, 0, 0));
    send_word(make_word(32767, -32768, 32767, 16384, 0, 0, 0));
    send_word(make_word(-32768, 32767, -32768, 16384, 0, 0, 0));
    send_word(make_word(-5, 7, -9, -16384, 0, 0, 0));
    // quarter turns about each axis, half turn about z
    send_word(make_word(0, 1000, 0, 11585, 11585, 0, 0));
    send_word(make_word(0, 0, 1000, 11585, 0, 11585, 0));
    send_word(make_word(1000, 0, 0, 11585, 0, 0, 11585));
    send_word(make_word(12345, -6789, 100, 0, 0, 0, 16384));
    // zero quaternion
    send_word(make_word(32767, 32767, 32767, 0, 0, 0, 0));
    send_word(make_word(-32768, -32768, -32768, 0, 0, 0, 0));
    // oversized quaternions, saturating both ways
    send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_word(make_word(20000, -20000, 100, 32767, 0, 0, 0));
    send_word(make_word(1, -1, 1, -32768, -32768, -32768, -32768));
    send_word(make_word(0, 0, 0, 32767, -32768, 32767, -32768));
    send_word(make_word(32767, -32768, 0, 0, 32767, -32768, 0));
    // half-scale quaternion, rounding ties
    send_word(make_word(1, -1, 3, 8192, 0, 0, 0));
    send_word(make_word(-3, 3, -1, 8192, 0, 0, 0));
    send_word(make_word(-1, 1, -1, 0, 8192, 8192, 0));
    wait_results();
  endtask

  task automatic test_random_rotations(input int n_words);
    throttle_en = 1'b1;
    repeat (n_words) send_word(random_rotation($urandom_range(3) == 0));
    wait_results();
  endtask

  task automatic test_random_raw(input int n_words);
    throttle_en = 1'b1;
    for (int i = 0; i < n_words; i++) begin
      send_word(in_word_t'({$urandom, $urandom, $urandom, $urandom}));
      if (i % 64 == 63) wait_results();
    end
    wait_results();
  endtask

  task automatic test_back_to_back(input int n_words);
    throttle_en = 1'b0;
    for (int i = 0; i < n_words; i++) begin
      if (i % 2 == 0) send_word(random_rotation(1'b0));
      else send_word(in_word_t'({$urandom, $urandom, $urandom, $urandom}));
    end
    wait_results();
    throttle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_rotations(400);
    test_random_raw(300);
    test_back_to_back(300);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (rot_expected_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/qvr_pkg.sv
src/qvr_conj_mul.sv
src/qvr_vec_mul.sv
src/quaternion_vector_rotation.sv
test/tb_quaternion_vector_rotation.sv
